[design/bvm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvm_pkg
// Shared widths, constants, register codes and state codes of the battery
// voltage monitor.
// ----------------------------------------------------------------------------
package bvm_pkg;

  // default ADC sample width
  localparam int unsigned SAMPLE_BITS_DEF = 12;

  // datapath widths
  localparam int unsigned SUM_W      = 20;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned MV_W       = 16;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned RATIO_W    = 16;
  localparam int unsigned OP_W       = 32;
  localparam int unsigned DEN_W      = 16;
  localparam int unsigned MUL_B_W    = 16;
  localparam int unsigned Q_FRAC     = 12;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  // scaling constants
  localparam logic [MUL_B_W-1:0] TAP_FULL_MV = MUL_B_W'(3300);
  localparam logic [PCT_W-1:0]   PCT_FULL    = PCT_W'(100);

  // reset values
  localparam logic [MV_W-1:0]    CUR_MV_RST       = MV_W'(9000);
  localparam logic [CNT_W-1:0]   SAMPLE_COUNT_RST = CNT_W'(8);
  localparam logic [RATIO_W-1:0] RATIO_RST        = RATIO_W'(4096);
  localparam logic [MV_W-1:0]    MIN_MV_RST       = MV_W'(6000);
  localparam logic [MV_W-1:0]    MAX_MV_RST       = MV_W'(9000);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_COUNT  = 8'd0,
    REG_DIVIDER_RATIO = 8'd1,
    REG_MIN_MV        = 8'd2,
    REG_MAX_MV        = 8'd3
  } cfg_reg_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AVG_DIV,
    ST_SCALE_MUL,
    ST_TAP_DIV,
    ST_RATIO_MUL,
    ST_PCT,
    ST_PCT_MUL,
    ST_PCT_DIV,
    ST_OUT
  } state_e;

endpackage

[design/battery_voltage_monitor_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_voltage_monitor_top
// Averaging battery gauge: burst average of ADC samples, scaled to battery
// millivolts through a Q4.12 divider ratio, with a linear charge percent.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one ADC sample and its ok
//   flag per beat. Every sample_count beats close a burst, and the output
//   channel (out_valid_o / out_ready_i) then carries one beat with the
//   battery voltage, the charge percent and the empty-burst flag.
//   Configuration writes use cfg_valid_i / cfg_ready_o with a register index
//   and data; cfg_ready_o is always high and unknown indexes are dropped.
//   A sample that does not close a burst is taken straight into the burst
//   accumulators. A closing sample starts a sequencer that shares one
//   bit-serial divider and one bit-serial multiplier; an empty burst skips
//   the average and scaling steps and goes straight to the percent step, and
//   a clamped percent skips its multiply and divide. in_ready_o stays low
//   until the sequencer is back in idle.
//   Results sit in an output register: samples of the next burst are taken
//   while a result waits, and a finished burst holds in its last state
//   until the receiver frees the output register.
//   Reset clears the burst accumulators, sets the stored voltage to 9000 mV
//   and loads the default configuration; no result is pending after reset.
// ----------------------------------------------------------------------------
module battery_voltage_monitor_top #(
  parameter int unsigned SAMPLE_BITS = bvm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bvm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [bvm_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // sample input
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [SAMPLE_BITS-1:0]            raw_sample_i,
  input  logic                              sample_ok_i,
  // result output
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [bvm_pkg::MV_W-1:0]          battery_mv_o,
  output logic [bvm_pkg::PCT_W-1:0]         percent_o,
  output logic                              no_valid_sample_o
);

  localparam int unsigned SUM_W   = bvm_pkg::SUM_W;
  localparam int unsigned CNT_W   = bvm_pkg::CNT_W;
  localparam int unsigned MV_W    = bvm_pkg::MV_W;
  localparam int unsigned PCT_W   = bvm_pkg::PCT_W;
  localparam int unsigned RATIO_W = bvm_pkg::RATIO_W;
  localparam int unsigned OP_W    = bvm_pkg::OP_W;
  localparam int unsigned DEN_W   = bvm_pkg::DEN_W;
  localparam int unsigned MUL_B_W = bvm_pkg::MUL_B_W;
  localparam int unsigned Q_FRAC  = bvm_pkg::Q_FRAC;
  localparam int unsigned SAT_LSB = Q_FRAC + MV_W;

  localparam logic [DEN_W-1:0] FULL_SCALE = DEN_W'((2 ** SAMPLE_BITS) - 1);

  // configuration registers
  logic [CNT_W-1:0]   sample_count_q;
  logic [RATIO_W-1:0] ratio_q;
  logic [MV_W-1:0]    min_mv_q;
  logic [MV_W-1:0]    max_mv_q;

  // sequencer and burst state
  bvm_pkg::state_e    state_q, state_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [CNT_W-1:0]   attempt_q, attempt_d;
  logic [CNT_W-1:0]   valid_q, valid_d;
  logic [MV_W-1:0]    cur_mv_q, cur_mv_d;

  // burst result under construction
  logic [MV_W-1:0]    batt_q, batt_d;
  logic [PCT_W-1:0]   pct_q, pct_d;
  logic               empty_q, empty_d;

  // output register
  logic               out_valid_q, out_valid_d;
  logic [MV_W-1:0]    out_mv_q, out_mv_d;
  logic [PCT_W-1:0]   out_pct_q, out_pct_d;
  logic               out_empty_q, out_empty_d;

  // shared arithmetic units
  logic               div_start, div_done;
  logic [OP_W-1:0]    div_num, div_quot;
  logic [DEN_W-1:0]   div_den;
  logic               mul_start, mul_done;
  logic [OP_W-1:0]    mul_a, mul_prod;
  logic [MUL_B_W-1:0] mul_b;

  // accumulate helpers
  logic               in_beat;
  logic [SUM_W:0]     sum_add;
  logic [SUM_W-1:0]   sum_acc;
  logic [SUM_W-1:0]   sum_new;
  logic [CNT_W-1:0]   valid_new;
  logic [CNT_W-1:0]   attempt_new;
  logic [CNT_W-1:0]   burst_len;
  logic               burst_end;
  logic [MV_W-1:0]    batt_sat;

  assign cfg_ready_o = 1'b1;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q <= bvm_pkg::SAMPLE_COUNT_RST;
      ratio_q        <= bvm_pkg::RATIO_RST;
      min_mv_q       <= bvm_pkg::MIN_MV_RST;
      max_mv_q       <= bvm_pkg::MAX_MV_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bvm_pkg::REG_SAMPLE_COUNT:  sample_count_q <= cfg_data_i[CNT_W-1:0];
        bvm_pkg::REG_DIVIDER_RATIO: ratio_q        <= cfg_data_i[RATIO_W-1:0];
        bvm_pkg::REG_MIN_MV:        min_mv_q       <= cfg_data_i[MV_W-1:0];
        bvm_pkg::REG_MAX_MV:        max_mv_q       <= cfg_data_i[MV_W-1:0];
        default: ;
      endcase
    end
  end

  // saturating accumulate and burst end detect
  always_comb begin
    in_beat     = in_valid_i && in_ready_o;
    sum_add     = {1'b0, sum_q} + (SUM_W + 1)'(raw_sample_i);
    sum_acc     = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
    sum_new     = sample_ok_i ? sum_acc : sum_q;
    valid_new   = valid_q + CNT_W'(sample_ok_i);
    attempt_new = attempt_q + CNT_W'(1);
    burst_len   = (sample_count_q == '0) ? CNT_W'(1) : sample_count_q;
    burst_end   = attempt_new >= burst_len;
    batt_sat    = (|mul_prod[OP_W-1:SAT_LSB]) ? '1 : mul_prod[SAT_LSB-1:Q_FRAC];
  end

  assign in_ready_o = (state_q == bvm_pkg::ST_IDLE);

  // sequencer: next state, unit launches and register updates
  always_comb begin
    state_d     = state_q;
    sum_d       = sum_q;
    attempt_d   = attempt_q;
    valid_d     = valid_q;
    cur_mv_d    = cur_mv_q;
    batt_d      = batt_q;
    pct_d       = pct_q;
    empty_d     = empty_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_mv_d    = out_mv_q;
    out_pct_d   = out_pct_q;
    out_empty_d = out_empty_q;
    div_start   = 1'b0;
    div_num     = mul_prod;
    div_den     = FULL_SCALE;
    mul_start   = 1'b0;
    mul_a       = div_quot;
    mul_b       = bvm_pkg::TAP_FULL_MV;

    case (state_q)
      bvm_pkg::ST_IDLE: begin
        if (in_beat) begin
          if (burst_end) begin
            sum_d     = '0;
            attempt_d = '0;
            valid_d   = '0;
            if (valid_new == '0) begin
              batt_d  = '0;
              empty_d = 1'b1;
              state_d = bvm_pkg::ST_PCT;
            end else begin
              empty_d   = 1'b0;
              div_start = 1'b1;
              div_num   = OP_W'(sum_new);
              div_den   = DEN_W'(valid_new);
              state_d   = bvm_pkg::ST_AVG_DIV;
            end
          end else begin
            sum_d     = sum_new;
            attempt_d = attempt_new;
            valid_d   = valid_new;
          end
        end
      end
      // average ready: scale by the tap full-scale voltage
      bvm_pkg::ST_AVG_DIV: begin
        if (div_done) begin
          mul_start = 1'b1;
          mul_a     = div_quot;
          mul_b     = bvm_pkg::TAP_FULL_MV;
          state_d   = bvm_pkg::ST_SCALE_MUL;
        end
      end
      // divide by the ADC full-scale code
      bvm_pkg::ST_SCALE_MUL: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_num   = mul_prod;
          div_den   = FULL_SCALE;
          state_d   = bvm_pkg::ST_TAP_DIV;
        end
      end
      // tap millivolts ready: apply the divider ratio
      bvm_pkg::ST_TAP_DIV: begin
        if (div_done) begin
          mul_start = 1'b1;
          mul_a     = div_quot;
          mul_b     = MUL_B_W'(ratio_q);
          state_d   = bvm_pkg::ST_RATIO_MUL;
        end
      end
      // drop the fraction, saturate, store as the current voltage
      bvm_pkg::ST_RATIO_MUL: begin
        if (mul_done) begin
          batt_d   = batt_sat;
          cur_mv_d = batt_sat;
          state_d  = bvm_pkg::ST_PCT;
        end
      end
      // clamp cases of the percent, else scale the offset by 100
      bvm_pkg::ST_PCT: begin
        if ((max_mv_q <= min_mv_q) || (cur_mv_q <= min_mv_q)) begin
          pct_d   = '0;
          state_d = bvm_pkg::ST_OUT;
        end else if (cur_mv_q >= max_mv_q) begin
          pct_d   = bvm_pkg::PCT_FULL;
          state_d = bvm_pkg::ST_OUT;
        end else begin
          mul_start = 1'b1;
          mul_a     = OP_W'(cur_mv_q - min_mv_q);
          mul_b     = MUL_B_W'(bvm_pkg::PCT_FULL);
          state_d   = bvm_pkg::ST_PCT_MUL;
        end
      end
      // divide by the voltage span
      bvm_pkg::ST_PCT_MUL: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_num   = mul_prod;
          div_den   = DEN_W'(max_mv_q - min_mv_q);
          state_d   = bvm_pkg::ST_PCT_DIV;
        end
      end
      bvm_pkg::ST_PCT_DIV: begin
        if (div_done) begin
          pct_d   = div_quot[PCT_W-1:0];
          state_d = bvm_pkg::ST_OUT;
        end
      end
      // hand the result over once the output register is free
      bvm_pkg::ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_mv_d    = batt_q;
          out_pct_d   = pct_q;
          out_empty_d = empty_q;
          state_d     = bvm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bvm_pkg::ST_IDLE;
      end
    endcase
  end

  // control and burst state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bvm_pkg::ST_IDLE;
      sum_q       <= '0;
      attempt_q   <= '0;
      valid_q     <= '0;
      cur_mv_q    <= bvm_pkg::CUR_MV_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      attempt_q   <= attempt_d;
      valid_q     <= valid_d;
      cur_mv_q    <= cur_mv_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    batt_q      <= batt_d;
    pct_q       <= pct_d;
    empty_q     <= empty_d;
    out_mv_q    <= out_mv_d;
    out_pct_q   <= out_pct_d;
    out_empty_q <= out_empty_d;
  end

  // shared bit-serial divider
  bvm_serial_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // shared bit-serial multiplier
  bvm_serial_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  assign out_valid_o       = out_valid_q;
  assign battery_mv_o      = out_mv_q;
  assign percent_o         = out_pct_q;
  assign no_valid_sample_o = out_empty_q;

endmodule

[design/bvm_serial_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvm_serial_div
// Bit-serial restoring divider: one quotient bit per cycle; done pulses for
// one cycle once the last step is registered.
// ----------------------------------------------------------------------------
module bvm_serial_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [bvm_pkg::OP_W-1:0]    num_i,
  input  logic [bvm_pkg::DEN_W-1:0]   den_i,
  output logic                        done_o,
  output logic [bvm_pkg::OP_W-1:0]    quot_o
);

  localparam int unsigned OP_W  = bvm_pkg::OP_W;
  localparam int unsigned DEN_W = bvm_pkg::DEN_W;
  localparam int unsigned STP_W = $clog2(OP_W + 1);

  logic [OP_W-1:0]  num_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [STP_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [DEN_W:0]   partial;
  logic [DEN_W:0]   trial;
  logic             fits;

  // one restoring step: shift in the next dividend bit and try a subtract
  always_comb begin
    partial = {rem_q, num_q[OP_W-1]};
    trial   = partial - {1'b0, den_q};
    fits    = partial >= {1'b0, den_q};
  end

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == STP_W'(1)) && !start_i;
      if (start_i) begin
        cnt_q  <= STP_W'(OP_W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - STP_W'(1);
        if (cnt_q == STP_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // shift registers: quotient bits replace dividend bits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[OP_W-2:0], fits};
      rem_q <= fits ? trial[DEN_W-1:0] : partial[DEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

[design/bvm_serial_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvm_serial_mul
// Bit-serial shift-add multiplier: one multiplier bit per cycle; done pulses
// for one cycle once the last step is registered.
// ----------------------------------------------------------------------------
module bvm_serial_mul (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [bvm_pkg::OP_W-1:0]     a_i,
  input  logic [bvm_pkg::MUL_B_W-1:0]  b_i,
  output logic                         done_o,
  output logic [bvm_pkg::OP_W-1:0]     prod_o
);

  localparam int unsigned OP_W  = bvm_pkg::OP_W;
  localparam int unsigned B_W   = bvm_pkg::MUL_B_W;
  localparam int unsigned STP_W = $clog2(B_W + 1);

  logic [OP_W-1:0]  acc_q;
  logic [OP_W-1:0]  a_q;
  logic [B_W-1:0]   b_q;
  logic [STP_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == STP_W'(1)) && !start_i;
      if (start_i) begin
        cnt_q  <= STP_W'(B_W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - STP_W'(1);
        if (cnt_q == STP_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // add the shifted multiplicand for each set multiplier bit
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q   <= a_i;
      b_q   <= b_i;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= {a_q[OP_W-2:0], 1'b0};
      b_q <= {1'b0, b_q[B_W-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

[design/bvm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvm_checker
// Port-level checks of the battery voltage monitor, bound to the top level.
// ----------------------------------------------------------------------------
module bvm_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        out_valid_o,
  input  logic                        out_ready_i,
  input  logic [bvm_pkg::MV_W-1:0]    battery_mv_o,
  input  logic [bvm_pkg::PCT_W-1:0]   percent_o,
  input  logic                        no_valid_sample_o
);

  // no result beat is offered while in reset
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result beat offered during reset");

  // a stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(battery_mv_o)
      && $stable(percent_o) && $stable(no_valid_sample_o))
    else $error("stalled result beat changed");

  // percent never exceeds full charge
  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> percent_o <= bvm_pkg::PCT_FULL)
    else $error("percent above full charge");

  // an empty burst reports zero millivolts
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_valid_sample_o |-> battery_mv_o == '0)
    else $error("empty burst with nonzero voltage");

endmodule

bind battery_voltage_monitor_top bvm_checker u_bvm_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .battery_mv_o      (battery_mv_o),
  .percent_o         (percent_o),
  .no_valid_sample_o (no_valid_sample_o)
);
